### hw/rtl/dccf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccf_pkg
// Types and constants shared by the control code text filter modules.
// ----------------------------------------------------------------------------
package dccf_pkg;

    typedef enum logic [2:0] {
        MODE_PLAIN   = 3'd0,
        MODE_TABRUN  = 3'd1,
        MODE_MATCH   = 3'd2,
        MODE_SUBCODE = 3'd3,
        MODE_LENGTH  = 3'd4,
        MODE_SKIPN   = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        CFG_KEEP_TABS    = 2'd0,
        CFG_TAB_WIDTH    = 2'd1,
        CFG_CRLF_NEWLINE = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        END_RUNNING = 2'd0,
        END_CLEAN   = 2'd1,
        END_IN_CMD  = 2'd2
    } end_status_t;

    // One decoded character (before tab and newline expansion) or the end mark.
    typedef struct packed {
        logic        emit;
        logic        is_end;
        end_status_t end_status;
        logic [7:0]  ch;
    } emit_t;

    localparam int RESULT_LIMIT = 16;

    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DASH      = 8'h2D;
    localparam logic [7:0] CODE_HYPH0   = 8'hA9;
    localparam logic [7:0] CODE_HYPH1   = 8'hAA;
    localparam logic [7:0] CODE_HYPH2   = 8'hAB;
    localparam logic [7:0] CODE_HSPACE  = 8'hA0;
    localparam logic [7:0] CODE_TABRUN  = 8'hC1;
    localparam logic [7:0] TAB_BIT_MASK = 8'h60;
    localparam logic [7:0] CODE_SGL_LO  = 8'hC0;
    localparam logic [7:0] CODE_SGL_HI  = 8'hCF;
    localparam logic [7:0] CODE_MULTI   = 8'hD0;
    localparam logic [7:0] CODE_COLUMN  = 8'hDC;
    localparam logic [7:0] CODE_PAGE    = 8'hD4;

endpackage

### hw/rtl/dccf_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccf_decode
// Parse state machine: classifies each accepted byte and yields at most one
// decoded character or the end mark.
// ----------------------------------------------------------------------------
module dccf_decode (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_fire,
    input  logic [7:0]     data_byte,
    input  logic           end_of_input,
    output dccf_pkg::emit_t dec
);

    dccf_pkg::mode_t mode_reg, mode_next;
    logic [7:0]      open_reg, open_next;
    logic [8:0]      skip_reg, skip_next;
    logic [8:0]      skip_dec;

    assign skip_dec = (skip_reg != 9'd0) ? (skip_reg - 9'd1) : 9'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= dccf_pkg::MODE_PLAIN;
            open_reg <= 8'd0;
            skip_reg <= 9'd0;
        end else if (in_fire) begin
            mode_reg <= mode_next;
            open_reg <= open_next;
            skip_reg <= skip_next;
        end
    end

    always_comb begin
        mode_next = mode_reg;
        if (end_of_input) begin
            mode_next = dccf_pkg::MODE_PLAIN;
        end else begin
            case (mode_reg)
                dccf_pkg::MODE_TABRUN: begin
                    if (data_byte == dccf_pkg::CODE_TABRUN) mode_next = dccf_pkg::MODE_PLAIN;
                end
                dccf_pkg::MODE_MATCH: begin
                    if (data_byte == open_reg) mode_next = dccf_pkg::MODE_PLAIN;
                end
                dccf_pkg::MODE_SUBCODE: mode_next = dccf_pkg::MODE_LENGTH;
                dccf_pkg::MODE_LENGTH:  mode_next = dccf_pkg::MODE_SKIPN;
                dccf_pkg::MODE_SKIPN: begin
                    if (skip_dec == 9'd0) mode_next = dccf_pkg::MODE_PLAIN;
                end
                default: begin
                    mode_next = dccf_pkg::MODE_PLAIN;
                    if (data_byte == dccf_pkg::CODE_TABRUN) begin
                        mode_next = dccf_pkg::MODE_TABRUN;
                    end else if (data_byte >= dccf_pkg::CODE_SGL_LO &&
                                 data_byte <= dccf_pkg::CODE_SGL_HI) begin
                        mode_next = dccf_pkg::MODE_MATCH;
                    end else if (data_byte >= dccf_pkg::CODE_MULTI) begin
                        if (data_byte == dccf_pkg::CODE_COLUMN ||
                            data_byte == dccf_pkg::CODE_PAGE) begin
                            mode_next = dccf_pkg::MODE_SUBCODE;
                        end else begin
                            mode_next = dccf_pkg::MODE_LENGTH;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        open_next      = open_reg;
        skip_next      = skip_reg;
        dec.emit       = 1'b0;
        dec.is_end     = 1'b0;
        dec.end_status = dccf_pkg::END_RUNNING;
        dec.ch         = 8'd0;
        if (end_of_input) begin
            open_next      = 8'd0;
            skip_next      = 9'd0;
            dec.emit       = 1'b1;
            dec.is_end     = 1'b1;
            dec.end_status = (mode_reg == dccf_pkg::MODE_PLAIN) ?
                             dccf_pkg::END_CLEAN : dccf_pkg::END_IN_CMD;
        end else begin
            case (mode_reg)
                dccf_pkg::MODE_TABRUN: begin
                    if ((data_byte & dccf_pkg::TAB_BIT_MASK) == 8'd0) begin
                        dec.emit = 1'b1;
                        dec.ch   = dccf_pkg::CH_TAB;
                    end
                end
                dccf_pkg::MODE_MATCH: begin
                    if (data_byte == open_reg) open_next = 8'd0;
                end
                dccf_pkg::MODE_SUBCODE: begin
                    if (data_byte == 8'd0) begin
                        dec.emit = 1'b1;
                        dec.ch   = (open_reg == dccf_pkg::CODE_COLUMN) ?
                                   dccf_pkg::CH_LF : dccf_pkg::CH_FF;
                    end
                    open_next = 8'd0;
                end
                dccf_pkg::MODE_LENGTH: begin
                    skip_next = {1'b0, data_byte} + 9'd1;
                end
                dccf_pkg::MODE_SKIPN: begin
                    skip_next = skip_dec;
                end
                default: begin
                    if (data_byte == dccf_pkg::CODE_HYPH0 || data_byte == dccf_pkg::CODE_HYPH1 ||
                        data_byte == dccf_pkg::CODE_HYPH2) begin
                        dec.emit = 1'b1;
                        dec.ch   = dccf_pkg::CH_DASH;
                    end else if (data_byte == dccf_pkg::CODE_HSPACE) begin
                        dec.emit = 1'b1;
                        dec.ch   = dccf_pkg::CH_SPACE;
                    end else if (data_byte == dccf_pkg::CODE_TABRUN) begin
                        dec.emit = 1'b0;
                    end else if (data_byte >= dccf_pkg::CODE_SGL_LO &&
                                 data_byte <= dccf_pkg::CODE_SGL_HI) begin
                        open_next = data_byte;
                    end else if (data_byte >= dccf_pkg::CODE_MULTI) begin
                        if (data_byte == dccf_pkg::CODE_COLUMN ||
                            data_byte == dccf_pkg::CODE_PAGE) begin
                            open_next = data_byte;
                        end
                    end else if (data_byte == dccf_pkg::CH_CR) begin
                        dec.emit = 1'b1;
                        dec.ch   = dccf_pkg::CH_LF;
                    end else if (data_byte == dccf_pkg::CH_LF || data_byte == dccf_pkg::CH_TAB ||
                                 data_byte >= dccf_pkg::CH_SPACE) begin
                        dec.emit = 1'b1;
                        dec.ch   = data_byte;
                    end
                end
            endcase
        end
    end

endmodule

### hw/rtl/dccf_expand.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccf_expand
// Result register: turns one decoded character into its output beats
// (tab to spaces, LF to CR LF, as configured) and holds each beat until taken.
// ----------------------------------------------------------------------------
module dccf_expand #(
    parameter int MAX_TAB_WIDTH = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            keep_tabs,
    input  logic [4:0]      tab_width,
    input  logic            crlf_newline,
    input  logic            load_valid,
    input  dccf_pkg::emit_t desc,
    output logic            free,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic [2:0]      m_tuser,
    output logic            m_tlast
);

    localparam int TabLimitInt = (MAX_TAB_WIDTH < dccf_pkg::RESULT_LIMIT) ?
                                 MAX_TAB_WIDTH : dccf_pkg::RESULT_LIMIT;
    localparam logic [4:0] TabLimit = 5'(TabLimitInt);

    logic                  busy_reg, busy_next;
    logic [4:0]            beats_reg, beats_next;
    logic                  cr_reg, cr_next;
    logic [7:0]            ch_reg;
    logic                  end_reg;
    dccf_pkg::end_status_t status_reg;

    logic [4:0] width_sat;
    logic [4:0] beats_in;
    logic       cr_in;
    logic       load;
    logic       out_fire;

    assign width_sat = (tab_width > TabLimit) ? TabLimit : tab_width;

    always_comb begin
        beats_in = 5'd1;
        cr_in    = 1'b0;
        if (!desc.is_end) begin
            if (desc.ch == dccf_pkg::CH_TAB) begin
                beats_in = keep_tabs ? 5'd1 : width_sat;
            end else if (desc.ch == dccf_pkg::CH_LF) begin
                beats_in = crlf_newline ? 5'd2 : 5'd1;
                cr_in    = crlf_newline;
            end
        end
    end

    assign out_fire = busy_reg && m_tready;
    assign free     = !busy_reg || (m_tready && beats_reg == 5'd1);
    assign load     = load_valid && desc.emit && beats_in != 5'd0;

    always_comb begin
        busy_next  = busy_reg;
        beats_next = beats_reg;
        cr_next    = cr_reg;
        if (load) begin
            busy_next  = 1'b1;
            beats_next = beats_in;
            cr_next    = cr_in;
        end else if (out_fire) begin
            beats_next = beats_reg - 5'd1;
            cr_next    = 1'b0;
            if (beats_reg == 5'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            beats_reg <= 5'd0;
            cr_reg    <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            beats_reg <= beats_next;
            cr_reg    <= cr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ch_reg     <= (desc.ch == dccf_pkg::CH_TAB && !keep_tabs) ?
                          dccf_pkg::CH_SPACE : desc.ch;
            end_reg    <= desc.is_end;
            status_reg <= desc.end_status;
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = end_reg ? 8'd0 : (cr_reg ? dccf_pkg::CH_CR : ch_reg);
    assign m_tuser  = {(end_reg ? status_reg : dccf_pkg::END_RUNNING), !end_reg};
    assign m_tlast  = (beats_reg == 5'd1);

endmodule

### hw/rtl/doc_control_code_text_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doc_control_code_text_filter_unit
// Filters document body bytes into plain text, one character per beat.
// ----------------------------------------------------------------------------
//  Channel  Direction  tdata            tuser                     tlast
//  s_       in         data_byte        end_of_input              -
//  m_       out        text_char        char_valid, end_status    last
//  cfg_     in         register write   -                         -
//
//  A byte is decoded in the cycle it is accepted and its first result beat
//  is offered in the next cycle; a byte giving one beat can follow every cycle
//  while m_tready is high. An expanded tab of w spaces (tab_width saturated to
//  MAX_TAB_WIDTH and 16) or a CR LF pair keeps s_tready low until its last
//  beat is being taken. Bytes giving no result are taken whenever the result
//  register is free. aresetn (synchronous) clears parse, config and beat state.
// ----------------------------------------------------------------------------
module doc_control_code_text_filter_unit #(
    parameter int MAX_TAB_WIDTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] text_char
    output logic [2:0] m_tuser,   // [0] char_valid, [2:1] end_status
    output logic       m_tlast,
    input  logic       cfg_we,
    input  logic [1:0] cfg_addr,
    input  logic [4:0] cfg_wdata
);

    logic            keep_tabs_reg;
    logic [4:0]      tab_width_reg;
    logic            crlf_reg;
    logic            in_fire;
    logic            free;
    dccf_pkg::emit_t dec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_tabs_reg <= 1'b0;
            tab_width_reg <= 5'd8;
            crlf_reg      <= 1'b0;
        end else if (cfg_we) begin
            case (dccf_pkg::cfg_index_t'(cfg_addr))
                dccf_pkg::CFG_KEEP_TABS:    keep_tabs_reg <= cfg_wdata[0];
                dccf_pkg::CFG_TAB_WIDTH:    tab_width_reg <= cfg_wdata;
                dccf_pkg::CFG_CRLF_NEWLINE: crlf_reg      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign s_tready = free;
    assign in_fire  = s_tvalid && s_tready;

    dccf_decode u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_fire      (in_fire),
        .data_byte    (s_tdata),
        .end_of_input (s_tuser),
        .dec          (dec)
    );

    dccf_expand #(
        .MAX_TAB_WIDTH (MAX_TAB_WIDTH)
    ) u_expand (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .keep_tabs    (keep_tabs_reg),
        .tab_width    (tab_width_reg),
        .crlf_newline (crlf_reg),
        .load_valid   (in_fire),
        .desc         (dec),
        .free         (free),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule
